// ===== rtl/shm_pkg.sv =====
package shm_pkg;

   // Input item as it arrives on the request channel
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } shm_req_type;

   // Digest, H0 first
   typedef struct packed {
      logic [31:0] digest_word0;
      logic [31:0] digest_word1;
      logic [31:0] digest_word2;
      logic [31:0] digest_word3;
      logic [31:0] digest_word4;
   } shm_rsp_type;

   // Work that the front hands to the back
   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_BYTE_END,
      CMD_END
   } shm_cmd_type;

   typedef struct packed {
      shm_cmd_type cmd;
      logic [7:0]  data_byte;
   } shm_entry_type;

   // Queue side of the front/back link
   typedef struct packed {
      logic          valid;
      shm_entry_type entry;
   } shm_queue_type;

   // Round constants
   localparam logic [31:0] K_00_19 = 32'h5A827999;
   localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
   localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
   localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

   // Initial chain value
   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LAST_FILL     = 6'h3f;
   localparam logic [5:0] LEN_START     = 6'd56;
   localparam logic [6:0] LAST_ROUND    = 7'd79;

endpackage

// ===== rtl/shm_front.sv =====
module shm_front import shm_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  shm_req_type   req_data,
   output shm_queue_type queue_head,
   input  logic          queue_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   shm_entry_type    entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             keep;
   logic             pop;
   shm_entry_type    entry;

   // Classify the incoming item; idle items are taken and dropped
   always_comb begin
      entry.data_byte = req_data.data_byte;
      if (req_data.byte_present) begin
         entry.cmd = req_data.end_of_message ? CMD_BYTE_END : CMD_BYTE;
      end else begin
         entry.cmd = CMD_END;
      end
   end

   assign req_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign accept   = req_push && !req_full;
   assign keep     = accept && (req_data.byte_present || req_data.end_of_message);
   assign pop      = queue_pop && (count_ff != '0);

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (keep) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(keep) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries; payload needs no reset
   always_ff @(posedge clock) begin
      if (keep) begin
         entries_ff[wr_ptr_ff] <= entry;
      end
   end

   assign queue_head.valid = (count_ff != '0);
   assign queue_head.entry = entries_ff[rd_ptr_ff];

endmodule

// ===== rtl/shm_back.sv =====
module shm_back import shm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  shm_queue_type queue_head,
   output logic          queue_pop,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output shm_rsp_type   rsp_data
);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_PAD,
      ST_ROUND,
      ST_ADD
   } state_type;

   typedef enum logic [1:0] {
      PH_MARK,
      PH_ZERO,
      PH_LEN
   } phase_type;

   state_type    state_ff, state_in;
   phase_type    phase_ff, phase_in;
   logic [5:0]   fill_ff, fill_in;
   logic [63:0]  total_ff, total_in;
   logic [6:0]   rnd_ff, rnd_in;
   logic [2:0]   len_cnt_ff, len_cnt_in;
   logic         final_ff, final_in;
   logic         resume_ff, resume_in;
   logic [31:0]  chain_ff [5];
   logic [31:0]  chain_in [5];
   logic [31:0]  work_ff [5];
   logic [31:0]  work_in [5];
   logic [511:0] sched_ff, sched_in;
   logic [63:0]  len_ff, len_in;
   logic         out_valid_ff, out_valid_in;
   shm_rsp_type  out_data_ff, out_data_in;

   logic         push_en;
   logic [7:0]   push_val;
   logic         go_pad;
   logic         slot_free;
   logic [31:0]  w0, w2, w8, w13, wx, wnew;
   logic [31:0]  f_val, k_val, t_val;
   logic [31:0]  sum [5];

   // Schedule taps: word j of the window sits at the top minus 32*j
   assign w0   = sched_ff[511:480];
   assign w2   = sched_ff[447:416];
   assign w8   = sched_ff[255:224];
   assign w13  = sched_ff[95:64];
   assign wx   = w13 ^ w8 ^ w2 ^ w0;
   assign wnew = {wx[30:0], wx[31]};

   // Round function and constant
   always_comb begin
      case (rnd_ff) inside
         [7'd0:7'd19]: begin
            f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
            k_val = K_00_19;
         end
         [7'd20:7'd39]: begin
            f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
            k_val = K_20_39;
         end
         [7'd40:7'd59]: begin
            f_val = (work_ff[1] & work_ff[2]) | (work_ff[1] & work_ff[3])
                  | (work_ff[2] & work_ff[3]);
            k_val = K_40_59;
         end
         default: begin
            f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
            k_val = K_60_79;
         end
      endcase
      t_val = {work_ff[0][26:0], work_ff[0][31:27]} + f_val + work_ff[4] + k_val + w0;
   end

   always_comb begin
      for (int i = 0; i < 5; i++) begin
         sum[i] = chain_ff[i] + work_ff[i];
      end
   end

   assign slot_free = !out_valid_ff || rsp_pop;

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      fill_in      = fill_ff;
      total_in     = total_ff;
      rnd_in       = rnd_ff;
      len_cnt_in   = len_cnt_ff;
      final_in     = final_ff;
      resume_in    = resume_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      sched_in     = sched_ff;
      len_in       = len_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      queue_pop    = 1'b0;
      push_en      = 1'b0;
      push_val     = queue_head.entry.data_byte;
      go_pad       = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (queue_head.valid) begin
               queue_pop = 1'b1;
               case (queue_head.entry.cmd)
                  CMD_BYTE: begin
                     push_en  = 1'b1;
                     total_in = total_ff + 64'd1;
                  end
                  CMD_BYTE_END: begin
                     push_en  = 1'b1;
                     total_in = total_ff + 64'd1;
                     go_pad   = 1'b1;
                  end
                  default: begin
                     go_pad = 1'b1;
                  end
               endcase
               if (go_pad) begin
                  state_in = ST_PAD;
                  phase_in = PH_MARK;
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            go_pad  = 1'b1;
            case (phase_ff)
               PH_MARK: begin
                  push_val = PAD_MARK_BYTE;
                  len_in   = {total_ff[60:0], 3'b000};
                  phase_in = (fill_ff + 6'd1 == LEN_START) ? PH_LEN : PH_ZERO;
                  len_cnt_in = '0;
               end
               PH_ZERO: begin
                  push_val = '0;
                  if (fill_ff + 6'd1 == LEN_START) begin
                     phase_in = PH_LEN;
                  end
               end
               default: begin
                  push_val   = len_ff[63:56];
                  len_in     = {len_ff[55:0], 8'h00};
                  len_cnt_in = len_cnt_ff + 3'd1;
                  if (len_cnt_ff == 3'd7) begin
                     final_in = 1'b1;
                     go_pad   = 1'b0;
                  end
               end
            endcase
         end
         ST_ROUND: begin
            work_in[4] = work_ff[3];
            work_in[3] = work_ff[2];
            work_in[2] = {work_ff[1][1:0], work_ff[1][31:2]};
            work_in[1] = work_ff[0];
            work_in[0] = t_val;
            sched_in   = {sched_ff[479:0], wnew};
            rnd_in     = rnd_ff + 7'd1;
            if (rnd_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         default: begin
            if (final_ff) begin
               // Emit the digest and reload for the next message
               if (slot_free) begin
                  out_valid_in             = 1'b1;
                  out_data_in.digest_word0 = sum[0];
                  out_data_in.digest_word1 = sum[1];
                  out_data_in.digest_word2 = sum[2];
                  out_data_in.digest_word3 = sum[3];
                  out_data_in.digest_word4 = sum[4];
                  chain_in[0] = H0_INIT;
                  chain_in[1] = H1_INIT;
                  chain_in[2] = H2_INIT;
                  chain_in[3] = H3_INIT;
                  chain_in[4] = H4_INIT;
                  total_in    = '0;
                  final_in    = 1'b0;
                  resume_in   = 1'b0;
                  phase_in    = PH_MARK;
                  state_in    = ST_LOAD;
               end
            end else begin
               chain_in = sum;
               state_in = resume_ff ? ST_PAD : ST_LOAD;
            end
         end
      endcase

      // Shift one byte into the block; a full block starts the rounds
      if (push_en) begin
         sched_in = {sched_ff[503:0], push_val};
         fill_in  = fill_ff + 6'd1;
         if (fill_ff == LAST_FILL) begin
            state_in  = ST_ROUND;
            resume_in = go_pad;
            rnd_in    = '0;
            work_in   = chain_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         phase_ff     <= PH_MARK;
         fill_ff      <= '0;
         total_ff     <= '0;
         rnd_ff       <= '0;
         len_cnt_ff   <= '0;
         final_ff     <= 1'b0;
         resume_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         chain_ff[0]  <= H0_INIT;
         chain_ff[1]  <= H1_INIT;
         chain_ff[2]  <= H2_INIT;
         chain_ff[3]  <= H3_INIT;
         chain_ff[4]  <= H4_INIT;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         total_ff     <= total_in;
         rnd_ff       <= rnd_in;
         len_cnt_ff   <= len_cnt_in;
         final_ff     <= final_in;
         resume_ff    <= resume_in;
         out_valid_ff <= out_valid_in;
         chain_ff     <= chain_in;
      end
      work_ff     <= work_in;
      sched_ff    <= sched_in;
      len_ff      <= len_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   // The last round always hands over to the chain update
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == LAST_ROUND) |=> (state_ff == ST_ADD))
      else $error("round sequence did not end in chain update");

   // Length bytes only fill the tail of a block
   a_len_place: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD && phase_ff == PH_LEN) |-> (fill_ff >= LEN_START))
      else $error("length bytes outside block tail");

   // Rounds start only on a complete block
   a_round_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) ##1 (state_ff == ST_ROUND) |-> (fill_ff == '0))
      else $error("compression started on partial block");

   // A waiting digest is never overwritten
   a_hold_digest: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_pop) |=> (out_valid_ff && $stable(out_data_ff)))
      else $error("pending digest lost");

endmodule

// ===== rtl/sha1_message_hash.sv =====
// Channel   Ports                          Transfer when
// --------  -----------------------------  ------------------------
// request   req_push  req_full  req_data   req_push && !req_full
// response  rsp_pop   rsp_empty rsp_data   rsp_pop && !rsp_empty
//
// The block loader takes message bytes one at a time; every 64 bytes the
// shared round unit runs 80 rounds and then one chain update.
// End of message adds 9 to 72 padding bytes, plus one or two more blocks through
// the round unit before the digest is loaded into the result register.
// The request queue (QUEUE_DEPTH items) keeps taking items while the rounds run.
// Synchronous reset loads the initial chain value and empties queue and result.
module sha1_message_hash import shm_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  shm_req_type req_data,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output shm_rsp_type rsp_data
);

   shm_queue_type queue_head;
   logic          queue_pop;

   // Accept, classify and queue items
   shm_front #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .queue_head (queue_head),
      .queue_pop  (queue_pop)
   );

   // Pack, pad, compress and emit
   shm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_head (queue_head),
      .queue_pop  (queue_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== tb/sv/sha1_message_hash_tb.sv =====
module sha1_message_hash_tb;
   import shm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET   = 1600;
   localparam int HOLD_CYCLES   = 2500;
   localparam int DRAIN_CYCLES  = 400;
   localparam int IDLE_PERCENT  = 17;

   // Well-known digests of the empty message and of "abc"
   localparam shm_rsp_type DIGEST_EMPTY = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
   localparam shm_rsp_type DIGEST_ABC   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

   typedef struct packed {
      shm_req_type item;
      logic        typed;
      shm_rsp_type digest;
   } hash_row_type;

   localparam int ROW_COUNT = 15;

   // Directed rows; a digest is typed in only where it is a known value
   hash_row_type directed_rows [ROW_COUNT] = '{
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, DIGEST_EMPTY},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hff, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h61, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h62, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h63, 1'b1, 1'b1}, 1'b1, DIGEST_ABC},
      '{'{8'h00, 1'b0, 1'b1}, 1'b1, DIGEST_EMPTY},
      '{'{8'hff, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h5a, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'ha5, 1'b0, 1'b1}, 1'b0, '0},
      '{'{8'hff, 1'b1, 1'b1}, 1'b0, '0},
      '{'{8'h00, 1'b1, 1'b1}, 1'b0, '0},
      '{'{8'h80, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h7f, 1'b1, 1'b1}, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   shm_req_type req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   shm_rsp_type rsp_data;

   // Hash state of the predictor
   logic [31:0] hash_chain [5];
   logic [7:0]  block_bytes [64];
   int unsigned block_fill;
   logic [63:0] message_bytes;

   shm_rsp_type digest_queue [$];
   int          items_sent;
   int          digests_checked;
   int          error_count;

   sha1_message_hash u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] rotate_left(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic void restart_hash();
      hash_chain[0] = H0_INIT;
      hash_chain[1] = H1_INIT;
      hash_chain[2] = H2_INIT;
      hash_chain[3] = H3_INIT;
      hash_chain[4] = H4_INIT;
      block_fill    = 0;
      message_bytes = '0;
   endfunction

   // Run the 80 rounds over the full block and fold into the chain
   function automatic void compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, t;
      int          i;
      int          s;
      for (i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      a = hash_chain[0];
      b = hash_chain[1];
      c = hash_chain[2];
      d = hash_chain[3];
      e = hash_chain[4];
      for (i = 0; i < 80; i++) begin
         s = i % 16;
         if (i >= 16)
            w[s] = rotate_left(w[(s+13)%16] ^ w[(s+8)%16] ^ w[(s+2)%16] ^ w[s], 1);
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K_00_19;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K_20_39;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_40_59;
         end else begin
            f = b ^ c ^ d;
            k = K_60_79;
         end
         t = rotate_left(a, 5) + f + e + k + w[s];
         e = d;
         d = c;
         c = rotate_left(b, 30);
         b = a;
         a = t;
      end
      hash_chain[0] += a;
      hash_chain[1] += b;
      hash_chain[2] += c;
      hash_chain[3] += d;
      hash_chain[4] += e;
   endfunction

   function automatic void absorb_byte(input logic [7:0] v);
      block_bytes[block_fill] = v;
      block_fill++;
      if (block_fill == 64) begin
         compress_block();
         block_fill = 0;
      end
   endfunction

   // Advance the hash by one item; return 1 with the digest on end of message
   function automatic bit hash_item(input shm_req_type item, output shm_rsp_type digest);
      logic [63:0] bit_length;
      int          i;
      digest = '0;
      if (item.byte_present) begin
         absorb_byte(item.data_byte);
         message_bytes++;
      end
      if (!item.end_of_message)
         return 1'b0;
      bit_length = message_bytes << 3;
      absorb_byte(PAD_MARK_BYTE);
      while (block_fill != LEN_START)
         absorb_byte(8'h00);
      for (i = 0; i < 8; i++)
         absorb_byte(bit_length[63-8*i -: 8]);
      digest = {hash_chain[0], hash_chain[1], hash_chain[2], hash_chain[3], hash_chain[4]};
      restart_hash();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s: got %08h want %08h", $realtime, what, got, want);
      error_count++;
   endtask

   // Offer one item, hold until its transfer, then log its digest if any
   task automatic send_item(input shm_req_type item, input logic typed,
                            input shm_rsp_type golden);
      shm_rsp_type digest;
      bit          steady;
      steady = items_sent >= 600 && items_sent < 900;
      if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         req_data <= shm_req_type'($urandom);
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      if (item.byte_present || item.end_of_message)
         items_sent++;
      if (hash_item(item, digest))
         digest_queue.push_back(typed ? golden : digest);
   endtask

   function automatic int pick_length();
      int r;
      int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      r = $urandom_range(0, 99);
      if (r < 10)
         return 0;
      if (r < 45)
         return $urandom_range(1, 12);
      if (r < 65)
         return edges[$urandom_range(0, 7)];
      if (r < 92)
         return $urandom_range(13, 70);
      return $urandom_range(71, 200);
   endfunction

   // Stimulus: directed rows, then random messages
   initial begin
      shm_req_type item;
      int          row;
      int          msg_len;
      int          n;
      bit          end_alone;
      bit          paused;
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      items_sent = 0;
      error_count = 0;
      paused    = 1'b0;
      restart_hash();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < ROW_COUNT; row++)
         send_item(directed_rows[row].item, directed_rows[row].typed,
                   directed_rows[row].digest);

      while (items_sent < ITEM_TARGET) begin
         msg_len   = pick_length();
         end_alone = msg_len == 0 || $urandom_range(0, 1) == 1;
         for (n = 0; n < msg_len; n++) begin
            // Sprinkle ignored items with noisy data
            if ($urandom_range(0, 99) < 8) begin
               item.data_byte      = 8'($urandom);
               item.byte_present   = 1'b0;
               item.end_of_message = 1'b0;
               send_item(item, 1'b0, '0);
            end
            item.data_byte      = 8'($urandom);
            item.byte_present   = 1'b1;
            item.end_of_message = n == msg_len - 1 && !end_alone;
            send_item(item, 1'b0, '0);
         end
         if (end_alone) begin
            item.data_byte      = 8'($urandom);
            item.byte_present   = 1'b0;
            item.end_of_message = 1'b1;
            send_item(item, 1'b0, '0);
         end
         // Pause once until every digest has drained
         if (!paused && items_sent >= 1000) begin
            paused = 1'b1;
            req_push <= 1'b0;
            do @(posedge clock); while (digest_queue.size() != 0);
         end
      end

      req_push <= 1'b0;
      while (digest_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("sha1_message_hash regression: pass");
      else
         $display("sha1_message_hash regression: fail");
      $finish;
   end

   // Result side: check each transfer, pop at random, hold off once
   initial begin
      shm_rsp_type want;
      bit          held;
      bit          steady;
      int          i;
      rsp_pop = 1'b0;
      digests_checked = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty && !reset) begin
            if (digest_queue.size() == 0) begin
               report_mismatch("digest with none expected", rsp_data.digest_word0, '0);
            end else begin
               want = digest_queue.pop_front();
               for (i = 0; i < 5; i++)
                  if (rsp_data[159-32*i -: 32] !== want[159-32*i -: 32])
                     report_mismatch($sformatf("digest %0d digest_word%0d", digests_checked, i),
                                     rsp_data[159-32*i -: 32], want[159-32*i -: 32]);
            end
            digests_checked++;
         end
         // Hold off long enough for the block to fill and stall its input
         if (digests_checked == 8 && !held) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         steady = digests_checked >= 20 && digests_checked < 30;
         rsp_pop <= steady || $urandom_range(0, 99) >= IDLE_PERCENT;
      end
   end

   // Stop a hung run
   initial begin
      #20_000_000;
      $display("sha1_message_hash regression: fail");
      $finish;
   end

endmodule
